### sv/aabb_pkg.sv
// Package for the body step block: register map, reset values, saturation helper.
// Used by aabb_body_step and its testbench.
package aabb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_MASS   = 3'd0,
        REG_DRAG   = 3'd1,
        REG_STEP   = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } reg_idx_t;

    localparam logic [30:0] MASS_RST   = 31'd65536;
    localparam logic [30:0] DRAG_RST   = 31'd0;
    localparam logic [16:0] STEP_RST   = 17'd1092;
    localparam logic [30:0] WIDTH_RST  = 31'd65536;
    localparam logic [30:0] HEIGHT_RST = 31'd65536;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX) return 32'sh7FFFFFFF;
        if (v < S32_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

### sv/aabb_body_step.sv
// Top level of the body step block: APB registers, sequencer, shared multiplier.
// Depends on aabb_pkg and aabb_div.
//
// Use: configure mass, drag, time_step and body size over APB while idle.
// Each input beat on s_* is either a tick (s_cmd = 0, force applied) or a
// tile check (s_cmd = 1, rectangle). Every input beat gives exactly one
// result beat on m_*: position and velocity after the item, plus m_hit.
// s_ready is high only while no item is in work or waiting on m_*.
// A tick runs three divisions on the shared restoring divider and the
// multiply steps around the shared 32x32 multiplier (two-stage,
// pipelined). A tile check runs through the edge, min/max, overlap and
// resolve stages.
// The result holds on m_* until m_ready; the next item is taken after that.
// Reset (synchronous, active low) zeroes position and velocity and loads
// the register reset values; no clearing pass is needed.
module aabb_body_step #(
    parameter int FRAC_BITS = aabb_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [aabb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic signed [31:0] s_force_x,
    input  logic signed [31:0] s_force_y,
    input  logic signed [31:0] s_tile_x,
    input  logic signed [31:0] s_tile_y,
    input  logic [30:0]       s_tile_w,
    input  logic [30:0]       s_tile_h,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic              m_hit
);
    import aabb_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int QW = 64 - FRAC_BITS;
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
    localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LIM_W, ST_MX_I, ST_MY_I, ST_FX_C, ST_FY_C, ST_DX_W, ST_DY_W,
        ST_VX_I, ST_VY_I, ST_VX_C, ST_VY_C, ST_PX_I, ST_PY_I, ST_PX_C, ST_PY_C,
        ST_T_EDGE, ST_T_MM, ST_T_OV, ST_T_RES, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [30:0] mass_reg, drag_reg, width_reg, height_reg;
    logic [16:0] step_reg;
    logic        wr_en;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg   <= MASS_RST;
            drag_reg   <= DRAG_RST;
            step_reg   <= STEP_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (wr_en) begin
            unique case (widx)
                REG_MASS:   mass_reg   <= pwdata[30:0];
                REG_DRAG:   drag_reg   <= pwdata[30:0];
                REG_STEP:   step_reg   <= pwdata[16:0];
                REG_WIDTH:  width_reg  <= pwdata[30:0];
                REG_HEIGHT: height_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_MASS:   prdata = {1'b0, mass_reg};
            REG_DRAG:   prdata = {1'b0, drag_reg};
            REG_STEP:   prdata = {15'b0, step_reg};
            REG_WIDTH:  prdata = {1'b0, width_reg};
            REG_HEIGHT: prdata = {1'b0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // effective mass and step
    logic [30:0] mass_eff;
    logic [31:0] dt_eff;
    assign mass_eff = (mass_reg == '0) ? 31'd1 : mass_reg;
    always_comb begin
        dt_eff = {15'b0, step_reg};
        if (step_reg == '0) dt_eff = 32'd1;
        else if (dt_eff > ONE_Q) dt_eff = ONE_Q;
    end

    // body state and scratch
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [31:0] fx_reg, fy_reg, tfx_reg, tfy_reg, ax_reg, ay_reg;
    logic signed [31:0] tx_reg, ty_reg;
    logic [30:0]        tw_reg, th_reg, cd_reg;
    logic               cmd_reg, hit_reg;
    logic signed [33:0] bx1_reg, by1_reg, tx1_reg, ty1_reg;
    logic signed [33:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [33:0] ox_reg, oy_reg;
    logic               ovl_reg;

    // shared multiplier: product, then truncation toward zero by 2^FRAC_BITS
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [QW-1:0] q_reg;
    logic signed [63:0] prod_adj;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MX_I: begin mul_a = signed'({1'b0, cd_reg}); mul_b = vx_reg; end
            ST_MY_I: begin mul_a = signed'({1'b0, cd_reg}); mul_b = vy_reg; end
            ST_VX_I: begin mul_a = ax_reg; mul_b = signed'(dt_eff); end
            ST_VY_I: begin mul_a = ay_reg; mul_b = signed'(dt_eff); end
            ST_PX_I: begin mul_a = vx_reg; mul_b = signed'(dt_eff); end
            ST_PY_I: begin mul_a = vy_reg; mul_b = signed'(dt_eff); end
            default: ;
        endcase
    end

    assign prod_adj = prod_reg + (prod_reg[63] ? BIAS : 64'sd0);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        q_reg    <= QW'(prod_adj >>> FRAC_BITS);
    end

    // divider
    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_q;
    logic [30:0]   div_divisor;
    logic [31:0]   tfx_mag, tfy_mag;
    logic          accept;

    assign accept  = s_valid && s_ready;
    assign tfx_mag = tfx_reg[31] ? 32'(-tfx_reg) : 32'(tfx_reg);
    assign tfy_mag = tfy_reg[31] ? 32'(-tfy_reg) : 32'(tfy_reg);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(mass_eff) << FRAC_BITS;
        div_divisor  = dt_eff[30:0];
        if (state_reg == ST_IDLE && accept && !s_cmd) begin
            div_start = 1'b1;
        end else if (state_reg == ST_FY_C) begin
            div_start    = 1'b1;
            div_dividend = DW'(tfx_mag) << FRAC_BITS;
            div_divisor  = mass_eff;
        end else if (state_reg == ST_DX_W && div_done) begin
            div_start    = 1'b1;
            div_dividend = DW'(tfy_mag) << FRAC_BITS;
            div_divisor  = mass_eff;
        end
    end

    aabb_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // signed quotient with saturation
    function automatic logic signed [31:0] qsat(input logic [DW-1:0] q, input logic neg);
        if (neg) begin
            if (q > DW'(32'h80000000)) return 32'sh80000000;
            return -signed'(q[31:0]);
        end
        if (q > DW'(32'h7FFFFFFF)) return 32'sh7FFFFFFF;
        return signed'(q[31:0]);
    endfunction

    logic signed [33:0] px_w, py_w;
    assign px_w = 34'(px_reg);
    assign py_w = 34'(py_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            px_reg    <= '0;
            py_reg    <= '0;
            vx_reg    <= '0;
            vy_reg    <= '0;
            hit_reg   <= 1'b0;
            cmd_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg <= s_cmd;
                        fx_reg  <= s_force_x;
                        fy_reg  <= s_force_y;
                        tx_reg  <= s_tile_x;
                        ty_reg  <= s_tile_y;
                        tw_reg  <= s_tile_w;
                        th_reg  <= s_tile_h;
                        hit_reg <= 1'b0;
                        state_reg <= s_cmd ? ST_T_EDGE : ST_LIM_W;
                    end
                end
                ST_LIM_W: begin
                    if (div_done) begin
                        cd_reg <= (DW'(drag_reg) < div_q) ? drag_reg : div_q[30:0];
                        state_reg <= ST_MX_I;
                    end
                end
                ST_MX_I: state_reg <= ST_MY_I;
                ST_MY_I: state_reg <= ST_FX_C;
                ST_FX_C: begin
                    tfx_reg   <= sat32(66'(fx_reg) - 66'(q_reg));
                    state_reg <= ST_FY_C;
                end
                ST_FY_C: begin
                    tfy_reg   <= sat32(66'(fy_reg) - 66'(q_reg));
                    state_reg <= ST_DX_W;
                end
                ST_DX_W: begin
                    if (div_done) begin
                        ax_reg    <= qsat(div_q, tfx_reg[31]);
                        state_reg <= ST_DY_W;
                    end
                end
                ST_DY_W: begin
                    if (div_done) begin
                        ay_reg    <= qsat(div_q, tfy_reg[31]);
                        state_reg <= ST_VX_I;
                    end
                end
                ST_VX_I: state_reg <= ST_VY_I;
                ST_VY_I: state_reg <= ST_VX_C;
                ST_VX_C: begin
                    vx_reg    <= sat32(66'(vx_reg) + 66'(q_reg));
                    state_reg <= ST_VY_C;
                end
                ST_VY_C: begin
                    vy_reg    <= sat32(66'(vy_reg) + 66'(q_reg));
                    state_reg <= ST_PX_I;
                end
                ST_PX_I: state_reg <= ST_PY_I;
                ST_PY_I: state_reg <= ST_PX_C;
                ST_PX_C: begin
                    px_reg    <= sat32(66'(px_reg) + 66'(q_reg));
                    state_reg <= ST_PY_C;
                end
                ST_PY_C: begin
                    py_reg    <= sat32(66'(py_reg) + 66'(q_reg));
                    state_reg <= ST_OUT;
                end
                ST_T_EDGE: begin
                    bx1_reg   <= px_w + signed'({3'b0, width_reg});
                    by1_reg   <= py_w + signed'({3'b0, height_reg});
                    tx1_reg   <= 34'(tx_reg) + signed'({3'b0, tw_reg});
                    ty1_reg   <= 34'(ty_reg) + signed'({3'b0, th_reg});
                    state_reg <= ST_T_MM;
                end
                ST_T_MM: begin
                    minx_reg  <= (bx1_reg < tx1_reg) ? bx1_reg : tx1_reg;
                    maxx_reg  <= (px_w > 34'(tx_reg)) ? px_w : 34'(tx_reg);
                    miny_reg  <= (by1_reg < ty1_reg) ? by1_reg : ty1_reg;
                    maxy_reg  <= (py_w > 34'(ty_reg)) ? py_w : 34'(ty_reg);
                    state_reg <= ST_T_OV;
                end
                ST_T_OV: begin
                    ox_reg    <= minx_reg - maxx_reg;
                    oy_reg    <= miny_reg - maxy_reg;
                    ovl_reg   <= (minx_reg > maxx_reg) && (miny_reg > maxy_reg);
                    state_reg <= ST_T_RES;
                end
                ST_T_RES: begin
                    hit_reg <= ovl_reg;
                    if (ovl_reg) begin
                        // push against the velocity sign; zero velocity leaves position
                        if (ox_reg < oy_reg) begin
                            if (vx_reg > 0)
                                px_reg <= sat32(66'(px_reg) - 66'(ox_reg));
                            else if (vx_reg < 0)
                                px_reg <= sat32(66'(px_reg) + 66'(ox_reg));
                            vx_reg <= '0;
                        end else begin
                            if (vy_reg > 0)
                                py_reg <= sat32(66'(py_reg) - 66'(oy_reg));
                            else if (vy_reg < 0)
                                py_reg <= sat32(66'(py_reg) + 66'(oy_reg));
                            vy_reg <= '0;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_pos_x = px_reg;
    assign m_pos_y = py_reg;
    assign m_vel_x = vx_reg;
    assign m_vel_y = vy_reg;
    assign m_hit   = hit_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input ready while result pending");
    a_hit_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> cmd_reg) else $error("hit on a tick");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready right after accept");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_LIM_W || state_reg == ST_DX_W
                     || state_reg == ST_DY_W) else $error("divider result unexpected");
endmodule

### sv/aabb_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
module aabb_div #(
    parameter int DW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [30:0]   divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] sh_reg;
    logic [30:0]   rem_reg;
    logic [30:0]   dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [31:0]   rem_sh;
    logic [32:0]   diff;

    assign rem_sh = {rem_reg, sh_reg[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_reg <= diff[30:0];
                sh_reg  <= {sh_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[30:0];
                sh_reg  <= {sh_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_cnt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !start |=> cnt_reg == $past(cnt_reg)) else $error("counter drift");
endmodule

### tb/sv/aabb_body_step_tb.sv
// Testbench for aabb_body_step: APB setup, tick and tile beats, scoreboard check.
// Depends on aabb_pkg and the aabb_body_step RTL.
`timescale 1ns / 1ps

class body_scoreboard;
    logic [31:0] mass_r, drag_r, step_r, width_r, height_r;
    longint pos_x, pos_y, vel_x, vel_y;
    logic [127:0] pending_q[$];
    logic pending_hit_q[$];
    int errors;

    function new();
        mass_r = 65536; drag_r = 0; step_r = 1092;
        width_r = 65536; height_r = 65536;
        pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
        errors = 0;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint qmul(longint a, longint b);
        return (a * b) / 65536;
    endfunction

    function longint sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function void set_reg(int idx, logic [31:0] v);
        case (idx)
            aabb_pkg::REG_MASS:   mass_r = v & 32'h7FFFFFFF;
            aabb_pkg::REG_DRAG:   drag_r = v & 32'h7FFFFFFF;
            aabb_pkg::REG_STEP:   step_r = v & 32'h1FFFF;
            aabb_pkg::REG_WIDTH:  width_r = v & 32'h7FFFFFFF;
            aabb_pkg::REG_HEIGHT: height_r = v & 32'h7FFFFFFF;
            default: ;
        endcase
    endfunction

    function void note_input(logic cmd, logic signed [31:0] fx, logic signed [31:0] fy,
                             logic signed [31:0] tx, logic signed [31:0] ty,
                             logic [30:0] tw, logic [30:0] th);
        longint m, dt, lim, cd, tfx, tfy, ax, ay;
        longint bx1, by1, tx1, ty1, minx, maxx, miny, maxy, ox, oy;
        logic hit;
        hit = 0;
        if (!cmd) begin
            m = (mass_r == 0) ? 1 : longint'(mass_r);
            dt = (step_r == 0) ? 1 : longint'(step_r);
            if (dt > 65536) dt = 65536;
            lim = (m * 65536) / dt;
            cd = (longint'(drag_r) < lim) ? longint'(drag_r) : lim;
            tfx = clamp32(longint'(fx) - qmul(cd, vel_x));
            tfy = clamp32(longint'(fy) - qmul(cd, vel_y));
            ax = clamp32((tfx * 65536) / m);
            ay = clamp32((tfy * 65536) / m);
            vel_x = clamp32(vel_x + qmul(ax, dt));
            vel_y = clamp32(vel_y + qmul(ay, dt));
            pos_x = clamp32(pos_x + qmul(vel_x, dt));
            pos_y = clamp32(pos_y + qmul(vel_y, dt));
        end else begin
            bx1 = pos_x + longint'(width_r);
            by1 = pos_y + longint'(height_r);
            tx1 = longint'(tx) + longint'(tw);
            ty1 = longint'(ty) + longint'(th);
            minx = (bx1 < tx1) ? bx1 : tx1;
            maxx = (pos_x > longint'(tx)) ? pos_x : longint'(tx);
            miny = (by1 < ty1) ? by1 : ty1;
            maxy = (pos_y > longint'(ty)) ? pos_y : longint'(ty);
            if (minx > maxx && miny > maxy) begin
                hit = 1;
                ox = minx - maxx;
                oy = miny - maxy;
                if (ox < oy) begin
                    pos_x = clamp32(pos_x - ox * sign_of(vel_x));
                    vel_x = 0;
                end else begin
                    pos_y = clamp32(pos_y - oy * sign_of(vel_y));
                    vel_y = 0;
                end
            end
        end
        pending_q.push_back({pos_x[31:0], pos_y[31:0], vel_x[31:0], vel_y[31:0]});
        pending_hit_q.push_back(hit);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_result(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                      logic [31:0] vy, logic h);
        logic [127:0] e;
        logic eh;
        if (pending_q.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
            return;
        end
        e = pending_q.pop_front();
        eh = pending_hit_q.pop_front();
        if (px !== e[127:96]) report_mismatch("pos_x", px, e[127:96]);
        if (py !== e[95:64]) report_mismatch("pos_y", py, e[95:64]);
        if (vx !== e[63:32]) report_mismatch("vel_x", vx, e[63:32]);
        if (vy !== e[31:0]) report_mismatch("vel_y", vy, e[31:0]);
        if (h !== eh) report_mismatch("hit", {31'd0, h}, {31'd0, eh});
    endtask
endclass

module aabb_body_step_tb;
    import aabb_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic s_cmd = 0;
    logic signed [31:0] s_force_x = 0, s_force_y = 0, s_tile_x = 0, s_tile_y = 0;
    logic [30:0] s_tile_w = 0, s_tile_h = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_pos_x, m_pos_y, m_vel_x, m_vel_y;
    logic m_hit;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    body_scoreboard board;

    always #2 aclk = ~aclk;

    aabb_body_step i_dut (.*);

    // receiver side: random stall, check at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_pos_x, m_pos_y, m_vel_x, m_vel_y, m_hit);
    end
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic apb_write(reg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        board.set_reg(idx, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // valid drops only while idling, so back-to-back beats keep it high
    task automatic send_beat(logic cmd, logic signed [31:0] fx, logic signed [31:0] fy,
                             logic signed [31:0] tx, logic signed [31:0] ty,
                             logic [30:0] tw, logic [30:0] th);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1; s_cmd <= cmd;
        s_force_x <= fx; s_force_y <= fy; s_tile_x <= tx; s_tile_y <= ty;
        s_tile_w <= tw; s_tile_h <= th;
        do @(posedge aclk); while (!s_ready);
        board.note_input(cmd, fx, fy, tx, ty, tw, th);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    // tile near the body so overlaps are common
    task automatic random_item(bit wide);
        logic [31:0] a, b;
        logic signed [31:0] tx, ty;
        a = $urandom; b = $urandom;
        if ($urandom_range(1)) begin
            send_beat(0, wide ? $signed(a) : $signed(a) >>> $urandom_range(20, 0),
                      wide ? $signed(b) : $signed(b) >>> $urandom_range(20, 0),
                      $urandom, $urandom, 31'($urandom), 31'($urandom));
        end else if ($urandom_range(9) == 0) begin
            send_beat(1, $urandom, $urandom, $urandom, $urandom,
                      31'($urandom), 31'($urandom));
        end else begin
            tx = board.pos_x[31:0] + $signed(32'($urandom_range(262144))) - 131072;
            ty = board.pos_y[31:0] + $signed(32'($urandom_range(262144))) - 131072;
            send_beat(1, $urandom, $urandom, tx, ty,
                      31'($urandom_range(196608)), 31'($urandom_range(196608)));
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(negedge aclk);
        aresetn <= 1;

        // directed: extremes, both commands, drag clamp, step clamp, zero sizes
        send_beat(0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0);
        send_beat(0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0);
        send_beat(1, 0, 0, board.pos_x[31:0], board.pos_y[31:0], 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_beat(1, 0, 0, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_beat(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0);
        send_beat(1, 0, 0, board.pos_x[31:0], board.pos_y[31:0], 0, 31'h7FFFFFFF);
        send_beat(1, 0, 0, board.pos_x[31:0], board.pos_y[31:0], 65536, 65536);
        drain();
        apb_write(REG_MASS, 0);
        apb_write(REG_DRAG, 32'h7FFFFFFF);
        apb_write(REG_STEP, 0);
        send_beat(0, 32'sh00010000, -32'sh00010000, 0, 0, 0, 0);
        send_beat(0, 12345, 32'sh7FFFFFFF, 0, 0, 0, 0);
        drain();
        apb_write(REG_MASS, 32'h7FFFFFFF);
        apb_write(REG_STEP, 32'h1FFFF);
        apb_write(REG_WIDTH, 0);
        apb_write(REG_HEIGHT, 32'h7FFFFFFF);
        send_beat(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0);
        send_beat(1, 0, 0, board.pos_x[31:0] - 1, board.pos_y[31:0], 10, 10);
        drain();
        apb_write(REG_STEP, 65536);
        apb_write(REG_WIDTH, 32'h7FFFFFFF);
        apb_write(REG_HEIGHT, 0);
        send_beat(1, 0, 0, board.pos_x[31:0], board.pos_y[31:0], 10, 10);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 6 : ((ph == 1) ? 74 : 0);
            recv_idle_pct = (ph == 0) ? 74 : ((ph == 1) ? 6 : 0);
            for (int set = 0; set < 5; set++) begin
                apb_write(REG_MASS, (set == 0) ? 1 : 32'($urandom_range(1 << 20, 1)));
                apb_write(REG_DRAG, (set == 1) ? 0 : 32'($urandom_range(1 << 19)));
                apb_write(REG_STEP, (set == 2) ? 1 : 32'($urandom_range(65536, 1)));
                apb_write(REG_WIDTH, 32'($urandom_range(1 << 18)));
                apb_write(REG_HEIGHT, 32'($urandom_range(1 << 18)));
                for (int n = 0; n < 68; n++) begin
                    random_item(set == 4);
                    if (n == 30) drain();
                end
                drain();
            end
        end

        apb_write(REG_MASS, MASS_RST);
        apb_write(REG_DRAG, DRAG_RST);
        apb_write(REG_STEP, STEP_RST);
        apb_write(REG_WIDTH, WIDTH_RST);
        apb_write(REG_HEIGHT, HEIGHT_RST);
        drain();
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
sv/aabb_pkg.sv
sv/aabb_div.sv
sv/aabb_body_step.sv
tb/sv/aabb_body_step_tb.sv
